// ===== rtl/sexp_bencode_token_parser_top_defines.svh =====
// Assertion macros shared by the bencode token parser RTL.
// No dependencies; included by sbtp_back, the module that carries assertions.
`ifndef SEXP_BENCODE_TOKEN_PARSER_TOP_DEFINES_SVH
`define SEXP_BENCODE_TOKEN_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SBTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SBTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sbtp_pkg.sv =====
// Shared types and constants of the bencode token parser.
// No dependencies; used by every module of the block.
`default_nettype none

package sbtp_pkg;

    localparam int SBTP_MAX_DEPTH   = 64;
    localparam int SBTP_MAX_DIGITS  = 9;
    localparam int SBTP_QUEUE_DEPTH = 4;
    localparam int VAL_W            = 30;
    localparam int DEPTH_W          = 7;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 7'd64;
    localparam logic [VAL_W-1:0]   ACC_MAX         = 30'h3FFF_FFFF;

    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        TK_OPEN   = 3'd0,
        TK_CLOSE  = 3'd1,
        TK_INT    = 3'd2,
        TK_LEN    = 3'd3,
        TK_BYTE   = 3'd4,
        TK_ACCEPT = 3'd5,
        TK_ERROR  = 3'd6
    } tok_kind_t;

    typedef enum logic [2:0] {
        BC_S     = 3'd0,
        BC_E     = 3'd1,
        BC_I     = 3'd2,
        BC_COLON = 3'd3,
        BC_DIGIT = 3'd4,
        BC_OTHER = 3'd5
    } byte_class_t;

    typedef enum logic [4:0] {
        PH_EXPECT     = 5'b00001,
        PH_INT_FIRST  = 5'b00010,
        PH_INT_DIGITS = 5'b00100,
        PH_LEN_DIGITS = 5'b01000,
        PH_DATA       = 5'b10000
    } phase_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic [7:0]  data;
        logic        last;
    } item_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [VAL_W-1:0]   value;
        logic [DEPTH_W-1:0] depth;
        logic               eor;
    } token_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/sbtp_front.sv =====
// Front end: accepts input bytes and classifies them for the back end.
// Depends on sbtp_pkg.
`default_nettype none

module sbtp_front (
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    input  wire sbtp_pkg::queue_status_t q_status,
    output logic                        push,
    output sbtp_pkg::item_t             push_item
);
    import sbtp_pkg::*;

    logic is_digit;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        push_item.data  = in_byte;
        push_item.last  = in_last;
        // '0'..'9' carry the digit in the low nibble
        push_item.digit = is_digit ? in_byte[3:0] : 4'd0;
        if (in_byte == CH_S)
        begin
            push_item.cls = BC_S;
        end
        else if (in_byte == CH_E)
        begin
            push_item.cls = BC_E;
        end
        else if (in_byte == CH_I)
        begin
            push_item.cls = BC_I;
        end
        else if (in_byte == CH_COLON)
        begin
            push_item.cls = BC_COLON;
        end
        else if (is_digit)
        begin
            push_item.cls = BC_DIGIT;
        end
        else
        begin
            push_item.cls = BC_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbtp_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on sbtp_pkg.
`default_nettype none

module sbtp_queue #(
    parameter int DEPTH = sbtp_pkg::SBTP_QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire sbtp_pkg::item_t         push_item,
    input  wire logic                    pop,
    output sbtp_pkg::item_t              head_item,
    output sbtp_pkg::queue_status_t      q_status
);
    import sbtp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t           slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head_item          = slots_reg[rd_ptr_reg];
    assign q_status.full      = (count_reg == FULL_CNT);
    assign q_status.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbtp_back.sv =====
// Back end: parser state, token generation and the output register.
// Depends on sbtp_pkg and sexp_bencode_token_parser_top_defines.svh.
`default_nettype none

`include "sexp_bencode_token_parser_top_defines.svh"

module sbtp_back #(
    parameter int MAX_DIGITS = sbtp_pkg::SBTP_MAX_DIGITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sbtp_pkg::DEPTH_W-1:0]  cfg_wdata,
    input  wire sbtp_pkg::item_t               item,
    input  wire logic                          item_valid,
    output logic                               pop,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output sbtp_pkg::token_t                   out_tok
);
    import sbtp_pkg::*;

    localparam int DCW = $clog2(MAX_DIGITS + 1);
    localparam logic [DCW-1:0] MAX_CNT = DCW'(MAX_DIGITS);
    localparam int LimCap = (SBTP_MAX_DEPTH > 127) ? 127 : SBTP_MAX_DEPTH;
    localparam logic [DEPTH_W-1:0] LIM_CAP = DEPTH_W'(LimCap);

    // parser state
    phase_t             phase_reg, phase_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [DCW-1:0]     cnt_reg, cnt_next;
    logic [VAL_W-1:0]   rem_reg, rem_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               lz_reg, lz_next;
    logic               top_done_reg, top_done_next;
    logic               err_reg, err_next;
    logic [DEPTH_W-1:0] depth_limit_reg;

    // output side
    logic   out_valid_reg, out_valid_next;
    token_t out_tok_reg, out_tok_next;
    logic   pend_valid_reg, pend_valid_next;
    token_t pend_tok_reg, pend_tok_next;

    logic [DEPTH_W-1:0] limit;
    logic [VAL_W+4:0]   prod;
    logic [VAL_W-1:0]   acc_step;
    logic [VAL_W-1:0]   rem_dec;
    logic               digit_ok;
    logic               done;
    logic               a_vld;
    token_t             tok_a;
    token_t             tok_fin;
    token_t             tok_first;
    logic [1:0]         ntok;
    logic               slot_free;
    logic               good;

    assign limit    = (depth_limit_reg < LIM_CAP) ? depth_limit_reg : LIM_CAP;
    assign prod     = ({5'd0, acc_reg} << 3) + ({5'd0, acc_reg} << 1)
                    + {31'd0, item.digit};
    assign acc_step = (prod > {5'd0, ACC_MAX}) ? ACC_MAX : prod[VAL_W-1:0];
    assign digit_ok = (item.cls == BC_DIGIT) && !lz_reg && (cnt_reg < MAX_CNT);
    assign rem_dec  = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    // next parser state for the head item
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        depth_next    = depth_reg;
        lz_next       = lz_reg;
        top_done_next = top_done_reg;
        err_next      = err_reg;
        done          = 1'b0;
        a_vld         = 1'b0;
        tok_a.kind    = TK_OPEN;
        tok_a.value   = '0;
        tok_a.eor     = 1'b0;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_EXPECT:
                begin
                    if (top_done_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        unique case (item.cls)
                            BC_S:
                            begin
                                if (depth_reg >= limit)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    depth_next = depth_reg + 1'b1;
                                    a_vld      = 1'b1;
                                    tok_a.kind = TK_OPEN;
                                end
                            end
                            BC_E:
                            begin
                                if (depth_reg == '0)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    depth_next = depth_reg - 1'b1;
                                    a_vld      = 1'b1;
                                    tok_a.kind = TK_CLOSE;
                                    done       = 1'b1;
                                end
                            end
                            BC_I:
                            begin
                                phase_next = PH_INT_FIRST;
                            end
                            BC_DIGIT:
                            begin
                                phase_next = PH_LEN_DIGITS;
                                acc_next   = VAL_W'(item.digit);
                                cnt_next   = DCW'(1);
                                lz_next    = (item.digit == 4'd0);
                            end
                            default:
                            begin
                                err_next = 1'b1;
                            end
                        endcase
                    end
                end
                PH_INT_FIRST:
                begin
                    if (item.cls == BC_DIGIT)
                    begin
                        phase_next = PH_INT_DIGITS;
                        acc_next   = VAL_W'(item.digit);
                        cnt_next   = DCW'(1);
                        lz_next    = (item.digit == 4'd0);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_INT_DIGITS:
                begin
                    if (item.cls == BC_E)
                    begin
                        a_vld       = 1'b1;
                        tok_a.kind  = TK_INT;
                        tok_a.value = acc_reg;
                        done        = 1'b1;
                    end
                    else if (digit_ok)
                    begin
                        acc_next = acc_step;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_LEN_DIGITS:
                begin
                    if (item.cls == BC_COLON)
                    begin
                        a_vld       = 1'b1;
                        tok_a.kind  = TK_LEN;
                        tok_a.value = acc_reg;
                        if (acc_reg == '0)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            rem_next   = acc_reg;
                            acc_next   = '0;
                            cnt_next   = '0;
                            lz_next    = 1'b0;
                            phase_next = PH_DATA;
                        end
                    end
                    else if (digit_ok)
                    begin
                        acc_next = acc_step;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    a_vld       = 1'b1;
                    tok_a.kind  = TK_BYTE;
                    tok_a.value = VAL_W'(item.data);
                    rem_next    = rem_dec;
                    done        = (rem_dec == '0);
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end
        if (done)
        begin
            phase_next = PH_EXPECT;
            acc_next   = '0;
            cnt_next   = '0;
            lz_next    = 1'b0;
            if (depth_next == '0)
            begin
                top_done_next = 1'b1;
            end
        end
        tok_a.depth = depth_next;

        // verdict at the last byte, taken before the clear
        good          = !err_next && (phase_next == PH_EXPECT) && (depth_next == '0)
                      && top_done_next;
        tok_fin.kind  = good ? TK_ACCEPT : TK_ERROR;
        tok_fin.value = '0;
        tok_fin.depth = depth_next;
        tok_fin.eor   = 1'b1;
        if (item.last)
        begin
            phase_next    = PH_EXPECT;
            acc_next      = '0;
            cnt_next      = '0;
            rem_next      = '0;
            depth_next    = '0;
            lz_next       = 1'b0;
            top_done_next = 1'b0;
            err_next      = 1'b0;
        end
    end

    // token slots and the pop decision
    always_comb
    begin
        ntok      = {1'b0, a_vld} + {1'b0, item.last};
        tok_first = a_vld ? tok_a : tok_fin;
        if (a_vld)
        begin
            tok_first.eor = !item.last;
        end
        slot_free = !out_valid_reg || out_ready;
        pop       = item_valid && !pend_valid_reg && ((ntok == 2'd0) || slot_free);

        out_valid_next  = out_valid_reg && !out_ready;
        out_tok_next    = out_tok_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        if (pend_valid_reg)
        begin
            // drain the second token of the previous item first
            if (slot_free)
            begin
                out_valid_next  = 1'b1;
                out_tok_next    = pend_tok_reg;
                pend_valid_next = 1'b0;
            end
        end
        else if (pop && (ntok != 2'd0))
        begin
            out_valid_next = 1'b1;
            out_tok_next   = tok_first;
            if (ntok == 2'd2)
            begin
                pend_valid_next = 1'b1;
                pend_tok_next   = tok_fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_EXPECT;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            rem_reg         <= '0;
            depth_reg       <= '0;
            lz_reg          <= 1'b0;
            top_done_reg    <= 1'b0;
            err_reg         <= 1'b0;
            depth_limit_reg <= DEPTH_LIMIT_RST;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                cnt_reg      <= cnt_next;
                rem_reg      <= rem_next;
                depth_reg    <= depth_next;
                lz_reg       <= lz_next;
                top_done_reg <= top_done_next;
                err_reg      <= err_next;
            end
            if (cfg_we)
            begin
                depth_limit_reg <= cfg_wdata;
            end
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        pend_tok_reg <= pend_tok_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

    `SBTP_ASSERT_NOW(a_pend_behind_out, clk, rst_n, pend_valid_reg, out_valid_reg, "pending token without a token in the output register")
    `SBTP_ASSERT_NOW(a_no_pop_while_pend, clk, rst_n, pend_valid_reg, !pop, "item taken while a second token still waits")
    `SBTP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, pop && item.last, (phase_reg == PH_EXPECT) && (depth_reg == '0) && !err_reg && !top_done_reg, "state not cleared after the last byte")
    `SBTP_ASSERT_NEXT(a_error_sticks, clk, rst_n, pop && err_reg && !item.last, err_reg && $stable(depth_reg), "error state left before the last byte")

endmodule

`default_nettype wire

// ===== rtl/sexp_bencode_token_parser_top.sv =====
// Top level of the bencode token parser: front end, item queue, back end.
// Depends on sbtp_pkg, sbtp_front, sbtp_queue and sbtp_back.
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    in_byte, in_last
//   out      out        out_valid/out_ready  token_kind, token_value, nest_depth, end_of_run
//   cfg      in         cfg_we               cfg_wdata (depth_limit)
//
// One input byte per cycle while in_ready is high; a last byte that also yields a token
// gives two tokens, the second held in a pending slot behind the one output port.
// The first token of a byte is presented from the output register; the byte itself
// waits in a queue slot before the back end takes it.
// Reset clears the parser state and the queue and sets depth_limit to 64.
// A stalled output fills the queue; in_ready drops only when the queue is full.
`default_nettype none

module sexp_bencode_token_parser_top #(
    parameter int MAX_DIGITS  = sbtp_pkg::SBTP_MAX_DIGITS,
    parameter int QUEUE_DEPTH = sbtp_pkg::SBTP_QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [sbtp_pkg::DEPTH_W-1:0] cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   in_byte,
    input  wire logic                         in_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [2:0]                        token_kind,
    output logic [sbtp_pkg::VAL_W-1:0]        token_value,
    output logic [sbtp_pkg::DEPTH_W-1:0]      nest_depth,
    output logic                              end_of_run
);
    import sbtp_pkg::*;

    queue_status_t q_status;
    logic          push;
    item_t         push_item;
    item_t         head_item;
    logic          pop;
    token_t        tok;

    sbtp_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sbtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    sbtp_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (head_item),
        .item_valid (q_status.not_empty),
        .pop        (pop),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_tok    (tok)
    );

    assign token_kind  = tok.kind;
    assign token_value = tok.value;
    assign nest_depth  = tok.depth;
    assign end_of_run  = tok.eor;

endmodule

`default_nettype wire
